>>> rtl/tdft_pkg.sv
package tdft_pkg;

    // Event codes
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_PRESS   = 2'd1;
    localparam logic [1:0] FUNC_MOVE    = 2'd2;
    localparam logic [1:0] FUNC_RELEASE = 2'd3;

    // Heading codes
    localparam logic [1:0] HEAD_NONE = 2'd0;
    localparam logic [1:0] HEAD_POS  = 2'd1;
    localparam logic [1:0] HEAD_NEG  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MOVE_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_TICK_PERIOD_MS = 2'd1;
    localparam logic [1:0] CFG_IDLE_LIMIT     = 2'd2;

    // Field and register widths
    localparam int TOUCH_W  = 12;
    localparam int THR_W    = 12;
    localparam int PERIOD_W = 8;
    localparam int IDLE_W   = 16;
    localparam int MS_W     = 16;
    localparam int SPEED_W  = 20;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Milliseconds per second, and the bits it takes
    localparam int MS_SCALE   = 1000;
    localparam int MS_SCALE_W = 10;

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
    localparam logic [MS_W-1:0]    MS_MAX    = {MS_W{1'b1}};
    localparam logic [IDLE_W-1:0]  IDLE_MAX  = {IDLE_W{1'b1}};

    // Reset values of the configuration registers
    localparam logic [THR_W-1:0]    THR_RESET    = 12'd8;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;
    localparam logic [IDLE_W-1:0]   IDLE_RESET   = 16'd50;

    typedef struct packed {
        logic [1:0]         func;
        logic [TOUCH_W-1:0] touch_x;
        logic [TOUCH_W-1:0] touch_y;
    } evt_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_x;
        logic [SPEED_W-1:0] speed_y;
        logic [1:0]         heading_x;
        logic [1:0]         heading_y;
        logic               dragging;
    } res_t;

endpackage

>>> rtl/touch_drag_flick_tracker_unit.sv
// Touch drag and flick tracker. Each accepted item is one touch event (tick, press, move or
// release) and gives exactly one result item carrying both axis speeds, both headings and the
// dragging flag as they stand after the event. A move or release while dragging runs S_MOVE
// for each axis, since one shared axis datapath applies the move to the horizontal and then the vertical axis.
// A tick while dragging runs, for each axis, S_TMUL to form travel*1000 on a single multiplier,
// then S_TDIV, where one restoring divider produces one quotient bit per cycle, then S_TFIN;
// the same divider serves both axes in turn. evt_stall stays high while an item is in work;
// the result register lets the next item enter while a finished result still waits on
// res_stall. Configuration writes are taken at any time but belong between items.
module touch_drag_flick_tracker_unit #(
    parameter int COORD_BITS  = 12,
    parameter int TRAVEL_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            evt_valid,
    output logic                            evt_stall,
    input  tdft_pkg::evt_t                  evt,
    output logic                            res_valid,
    input  logic                            res_stall,
    output tdft_pkg::res_t                  res,
    input  logic                            cfg_we,
    input  logic [tdft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdft_pkg::CFG_W-1:0]      cfg_data
);
    import tdft_pkg::*;

    // Offset is base minus touch, one bit wider than a coordinate.
    localparam int OFF_W = COORD_BITS + 1;
    // Compare width: room for offset differences and the negated threshold.
    localparam int DW    = (COORD_BITS + 2 > THR_W + 1) ? COORD_BITS + 2 : THR_W + 1;
    localparam int SUM_W = ((TRAVEL_BITS > DW) ? TRAVEL_BITS : DW) + 1;
    localparam int NUM_W = TRAVEL_BITS + MS_SCALE_W;
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [SUM_W-1:0] TRAVEL_MAX = SUM_W'({TRAVEL_BITS{1'b1}});

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOVE = 3'd1;
    localparam logic [2:0] S_TMUL = 3'd2;
    localparam logic [2:0] S_TDIV = 3'd3;
    localparam logic [2:0] S_TFIN = 3'd4;
    localparam logic [2:0] S_TEND = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    // Configuration
    logic [THR_W-1:0]    thr_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [IDLE_W-1:0]   idle_limit_reg;

    // Sequencer
    logic [2:0] state_reg;
    logic       axis_reg;
    evt_t       evt_reg;

    // Gesture state, one entry per axis (0 horizontal, 1 vertical)
    logic [COORD_BITS-1:0]   base_x_reg;
    logic [COORD_BITS-1:0]   base_y_reg;
    logic signed [OFF_W-1:0] last_off_reg [2];
    logic [1:0]              heading_reg  [2];
    logic [MS_W-1:0]         elapsed_reg  [2];
    logic [TRAVEL_BITS-1:0]  travel_reg   [2];
    logic [SPEED_W-1:0]      speed_reg    [2];
    logic                    active_reg;
    logic [IDLE_W-1:0]       idle_reg;

    // Divider
    logic [NUM_W-1:0]   num_reg;
    logic [MS_W-1:0]    div_reg;
    logic [MS_W-1:0]    rem_reg;
    logic [SPEED_W-1:0] quo_reg;
    logic               ovf_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // Result
    res_t res_reg;
    logic res_valid_reg;

    // ------------------------------------------------------------------
    // Move datapath for the selected axis
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0]   coord_x;
    logic [COORD_BITS-1:0]   coord_y;
    logic [COORD_BITS-1:0]   base_sel;
    logic [COORD_BITS-1:0]   coord_sel;
    logic signed [OFF_W-1:0] off_next;
    logic signed [DW-1:0]    p_s;
    logic signed [DW-1:0]    d_s;
    logic signed [DW-1:0]    t_s;
    logic signed [DW-1:0]    dn_s;
    logic signed [DW-1:0]    up_s;
    logic                    rev;
    logic [1:0]              heading_next;
    logic [DW-2:0]           mag;
    logic [TRAVEL_BITS-1:0]  travel_base;
    logic [SUM_W-1:0]        travel_sum;
    logic [TRAVEL_BITS-1:0]  travel_next;

    assign coord_x   = COORD_BITS'(evt_reg.touch_x);
    assign coord_y   = COORD_BITS'(evt_reg.touch_y);
    assign base_sel  = axis_reg ? base_y_reg : base_x_reg;
    assign coord_sel = axis_reg ? coord_y : coord_x;
    assign off_next  = signed'({1'b0, base_sel}) - signed'({1'b0, coord_sel});

    assign p_s  = DW'(last_off_reg[axis_reg]);
    assign d_s  = DW'(off_next);
    assign t_s  = signed'(DW'(thr_reg));
    assign dn_s = p_s - d_s;
    assign up_s = d_s - p_s;

    // Reversal needs the offset to move against the heading by more than the threshold.
    assign rev = ((heading_reg[axis_reg] == HEAD_POS) && (d_s < p_s) && (dn_s > t_s)) ||
                 ((heading_reg[axis_reg] == HEAD_NEG) && (d_s > p_s) && (up_s > t_s));

    always_comb
    begin
        heading_next = heading_reg[axis_reg];
        case (heading_reg[axis_reg])
            HEAD_POS:
            begin
                if (rev)
                begin
                    heading_next = HEAD_NEG;
                end
            end
            HEAD_NEG:
            begin
                if (rev)
                begin
                    heading_next = HEAD_POS;
                end
            end
            default:
            begin
                // From no direction, the offset itself must pass the threshold.
                if ((d_s > 0) && (d_s > t_s))
                begin
                    heading_next = HEAD_POS;
                end
                else if ((d_s < 0) && (d_s < -t_s))
                begin
                    heading_next = HEAD_NEG;
                end
            end
        endcase
    end

    assign mag         = dn_s[DW-1] ? up_s[DW-2:0] : dn_s[DW-2:0];
    assign travel_base = rev ? '0 : travel_reg[axis_reg];
    assign travel_sum  = SUM_W'(travel_base) + SUM_W'(mag);
    assign travel_next = (travel_sum > TRAVEL_MAX) ? {TRAVEL_BITS{1'b1}}
                                                   : travel_sum[TRAVEL_BITS-1:0];

    // ------------------------------------------------------------------
    // Tick datapath: elapsed time, numerator and one divider step
    // ------------------------------------------------------------------
    logic [MS_W:0]        el_sum;
    logic [MS_W-1:0]      elapsed_next;
    logic [MS_W-1:0]      div_next;
    logic [NUM_W-1:0]     num_next;
    logic [MS_W:0]        rem_sh;
    logic                 rem_ge;
    logic [MS_W-1:0]      rem_next;
    logic [SPEED_W-1:0]   speed_next;
    logic [IDLE_W-1:0]    idle_next;
    logic                 timeout;
    logic                 both_zero;

    assign el_sum       = {1'b0, elapsed_reg[axis_reg]} + (MS_W + 1)'(period_reg);
    assign elapsed_next = el_sum[MS_W] ? MS_MAX : el_sum[MS_W-1:0];
    assign div_next     = (elapsed_next == '0) ? MS_W'(1) : elapsed_next;
    assign num_next     = NUM_W'(travel_reg[axis_reg]) * NUM_W'(MS_SCALE);

    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, div_reg});
    assign rem_next = rem_ge ? MS_W'(rem_sh - {1'b0, div_reg}) : rem_sh[MS_W-1:0];

    // Any quotient bit above the speed width saturates.
    assign speed_next = ovf_reg ? SPEED_MAX : quo_reg;

    assign idle_next = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + IDLE_W'(1);
    assign timeout   = (idle_next > idle_limit_reg);
    assign both_zero = (speed_reg[0] == '0) && (speed_reg[1] == '0);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THR_RESET;
            period_reg     <= PERIOD_RESET;
            idle_limit_reg <= IDLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOVE_THRESHOLD: thr_reg        <= cfg_data[THR_W-1:0];
                CFG_TICK_PERIOD_MS: period_reg     <= cfg_data[PERIOD_W-1:0];
                CFG_IDLE_LIMIT:     idle_limit_reg <= cfg_data[IDLE_W-1:0];
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and gesture state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            base_x_reg    <= '0;
            base_y_reg    <= '0;
            for (int a = 0; a < 2; a++)
            begin
                last_off_reg[a] <= '0;
                heading_reg[a]  <= HEAD_NONE;
                elapsed_reg[a]  <= '0;
                travel_reg[a]   <= '0;
                speed_reg[a]    <= '0;
            end
            active_reg    <= 1'b0;
            idle_reg      <= '0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // Load a finished result when the register is free, else drop a taken one.
            if ((state_reg == S_DONE) && (!res_valid_reg || !res_stall))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (evt_valid)
                    begin
                        axis_reg <= 1'b0;
                        case (evt.func)
                            FUNC_TICK:
                            begin
                                state_reg <= active_reg ? S_TMUL : S_DONE;
                            end
                            FUNC_PRESS:
                            begin
                                // Latch the base point and start a fresh gesture.
                                base_x_reg <= COORD_BITS'(evt.touch_x);
                                base_y_reg <= COORD_BITS'(evt.touch_y);
                                for (int a = 0; a < 2; a++)
                                begin
                                    last_off_reg[a] <= '0;
                                    heading_reg[a]  <= HEAD_NONE;
                                    elapsed_reg[a]  <= '0;
                                    travel_reg[a]   <= '0;
                                    speed_reg[a]    <= '0;
                                end
                                active_reg <= 1'b1;
                                idle_reg   <= '0;
                                state_reg  <= S_DONE;
                            end
                            default:
                            begin
                                // Move or release: track while active, else start a gesture.
                                if (active_reg)
                                begin
                                    state_reg <= S_MOVE;
                                end
                                else
                                begin
                                    base_x_reg <= COORD_BITS'(evt.touch_x);
                                    base_y_reg <= COORD_BITS'(evt.touch_y);
                                    for (int a = 0; a < 2; a++)
                                    begin
                                        last_off_reg[a] <= '0;
                                        heading_reg[a]  <= HEAD_NONE;
                                        elapsed_reg[a]  <= '0;
                                        travel_reg[a]   <= '0;
                                        speed_reg[a]    <= '0;
                                    end
                                    active_reg <= 1'b1;
                                    idle_reg   <= '0;
                                    state_reg  <= S_DONE;
                                end
                            end
                        endcase
                    end
                end

                S_MOVE:
                begin
                    heading_reg[axis_reg]  <= heading_next;
                    travel_reg[axis_reg]   <= travel_next;
                    last_off_reg[axis_reg] <= off_next;
                    if (rev)
                    begin
                        elapsed_reg[axis_reg] <= '0;
                    end
                    if (axis_reg)
                    begin
                        if (evt_reg.func == FUNC_RELEASE)
                        begin
                            active_reg <= 1'b0;
                        end
                        idle_reg  <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        axis_reg <= 1'b1;
                    end
                end

                S_TMUL:
                begin
                    elapsed_reg[axis_reg] <= elapsed_next;
                    ovf_reg   <= 1'b0;
                    cnt_reg   <= CNT_W'(NUM_W - 1);
                    state_reg <= S_TDIV;
                end

                S_TDIV:
                begin
                    ovf_reg <= ovf_reg | quo_reg[SPEED_W-1];
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_TFIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end

                S_TFIN:
                begin
                    if (speed_next == '0)
                    begin
                        // No motion left on this axis: drop its tracking.
                        last_off_reg[axis_reg] <= '0;
                        heading_reg[axis_reg]  <= HEAD_NONE;
                        elapsed_reg[axis_reg]  <= '0;
                        travel_reg[axis_reg]   <= '0;
                        speed_reg[axis_reg]    <= '0;
                    end
                    else
                    begin
                        speed_reg[axis_reg] <= speed_next;
                    end
                    if (axis_reg)
                    begin
                        state_reg <= S_TEND;
                    end
                    else
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= S_TMUL;
                    end
                end

                S_TEND:
                begin
                    idle_reg <= idle_next;
                    // End the gesture when both axes stopped or the idle limit passed.
                    if (both_zero || timeout)
                    begin
                        active_reg <= 1'b0;
                        base_x_reg <= '0;
                        base_y_reg <= '0;
                        for (int a = 0; a < 2; a++)
                        begin
                            last_off_reg[a] <= '0;
                            heading_reg[a]  <= HEAD_NONE;
                            elapsed_reg[a]  <= '0;
                            travel_reg[a]   <= '0;
                            speed_reg[a]    <= '0;
                        end
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    // Hold until the result register is free.
                    if (!res_valid_reg || !res_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: event copy, divider datapath, result
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && evt_valid)
        begin
            evt_reg <= evt;
        end

        if (state_reg == S_TMUL)
        begin
            num_reg <= num_next;
            div_reg <= div_next;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (state_reg == S_TDIV)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SPEED_W-2:0], rem_ge};
        end

        if ((state_reg == S_DONE) && (!res_valid_reg || !res_stall))
        begin
            res_reg.speed_x   <= speed_reg[0];
            res_reg.speed_y   <= speed_reg[1];
            res_reg.heading_x <= heading_reg[0];
            res_reg.heading_y <= heading_reg[1];
            res_reg.dragging  <= active_reg;
        end
    end

    assign evt_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> rtl/tdft_checker.sv
module tdft_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            evt_valid,
    input  logic                            evt_stall,
    input  tdft_pkg::evt_t                  evt,
    input  logic                            res_valid,
    input  logic                            res_stall,
    input  tdft_pkg::res_t                  res
);
    import tdft_pkg::*;

    // Hold a stalled result.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result item dropped or changed");

    // Take no second item in the cycle after one is accepted.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_stall |=> evt_stall)
        else $error("event accepted while previous item in work");

    // Report only defined headings.
    a_heading_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.heading_x != 2'd3) && (res.heading_y != 2'd3))
        else $error("undefined heading code in result item");

    // A press always leaves the block dragging with no motion on either axis.
    a_press_result: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_stall && (evt.func == FUNC_PRESS) && !res_valid
        |=> ##1 res_valid && res.dragging && (res.speed_x == '0) && (res.speed_y == '0)
            && (res.heading_x == HEAD_NONE) && (res.heading_y == HEAD_NONE))
        else $error("press item did not start a clean gesture");

endmodule

bind touch_drag_flick_tracker_unit tdft_checker u_tdft_checker (.*);

>>> tb/touch_drag_flick_tracker_unit_tb.sv
`timescale 1ns / 1ps

module touch_drag_flick_tracker_unit_tb;

    import tdft_pkg::*;

    // Block widths at their default setting
    localparam int COORD_BITS  = 12;
    localparam int TRAVEL_BITS = 20;
    localparam longint TRAVEL_TOP = (longint'(1) << TRAVEL_BITS) - 1;
    localparam int COORD_TOP = (1 << COORD_BITS) - 1;

    // Cycles to let pass after the last result before a register write or the verdict.
    localparam int SETTLE_CYCLES = 2 * TRAVEL_BITS + 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 evt_valid = 1'b0;
    logic                 evt_stall;
    evt_t                 evt = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    res_t                 res;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    touch_drag_flick_tracker_unit #(
        .COORD_BITS  (COORD_BITS),
        .TRAVEL_BITS (TRAVEL_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Touch events waiting to be driven, and readouts the tracker should give back
    evt_t touch_queue[$];
    res_t readout_queue[$];
    bit   failed = 1'b0;

    // Threshold the stimulus aims its steps at, so that steps straddle it
    int   gen_thr = THR_RESET;

    // ------------------------------------------------------------------
    // Gesture tracker: own copy of the registers and the gesture state.
    // Everything is updated at the clock edge where the block takes it.
    // ------------------------------------------------------------------
    logic [THR_W-1:0]       c_thr    = THR_RESET;
    logic [PERIOD_W-1:0]    c_period = PERIOD_RESET;
    logic [IDLE_W-1:0]      c_idle   = IDLE_RESET;

    logic [COORD_BITS-1:0]  g_base[2]   = '{default: '0};
    logic signed [COORD_BITS:0] g_off[2] = '{default: '0};
    logic [1:0]             g_head[2]   = '{default: HEAD_NONE};
    logic [MS_W-1:0]        g_ms[2]     = '{default: '0};
    logic [TRAVEL_BITS-1:0] g_travel[2] = '{default: '0};
    logic [SPEED_W-1:0]     g_speed[2]  = '{default: '0};
    bit                     g_active    = 1'b0;
    logic [IDLE_W-1:0]      g_idle      = '0;

    function automatic void clear_axis(int a);
        g_off[a]    = '0;
        g_head[a]   = HEAD_NONE;
        g_ms[a]     = '0;
        g_travel[a] = '0;
        g_speed[a]  = '0;
    endfunction

    function automatic void start_gesture(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
        g_base[0] = x;
        g_base[1] = y;
        clear_axis(0);
        clear_axis(1);
    endfunction

    function automatic void end_gesture();
        g_active = 1'b0;
        start_gesture('0, '0);
    endfunction

    // Apply one move to an axis; pd is base minus touch, signed
    function automatic void move_axis(int a, int pd);
        int     prev;
        int     thr;
        int     delta;
        longint sum;
        prev = g_off[a];
        thr  = c_thr;
        case (g_head[a])
            HEAD_POS:
                if (pd < prev && prev - pd > thr) begin
                    // reversal: restart travel and time, this move still counts
                    g_head[a]   = HEAD_NEG;
                    g_travel[a] = '0;
                    g_ms[a]     = '0;
                end
            HEAD_NEG:
                if (pd > prev && pd - prev > thr) begin
                    g_head[a]   = HEAD_POS;
                    g_travel[a] = '0;
                    g_ms[a]     = '0;
                end
            default:
                // from no direction, the threshold applies on either side of zero
                if (pd > 0 && pd > thr)
                    g_head[a] = HEAD_POS;
                else if (pd < 0 && pd < -thr)
                    g_head[a] = HEAD_NEG;
        endcase
        delta = (prev > pd) ? prev - pd : pd - prev;
        sum = longint'(g_travel[a]) + delta;
        g_travel[a] = (sum > TRAVEL_TOP) ? TRAVEL_TOP[TRAVEL_BITS-1:0] : sum[TRAVEL_BITS-1:0];
        g_off[a] = pd[COORD_BITS:0];
    endfunction

    // Advance an axis by one tick: grow elapsed time, recompute speed
    function automatic void tick_axis(int a);
        longint ms;
        longint quo;
        ms = longint'(g_ms[a]) + longint'(c_period);
        if (ms > longint'(MS_MAX))
            ms = longint'(MS_MAX);
        g_ms[a] = ms[MS_W-1:0];
        // a zero period leaves elapsed time at zero; divide by one then
        quo = longint'(g_travel[a]) * MS_SCALE / ((ms == 0) ? 1 : ms);
        g_speed[a] = (quo > longint'(SPEED_MAX)) ? SPEED_MAX : quo[SPEED_W-1:0];
        if (g_speed[a] == '0)
            clear_axis(a);
    endfunction

    function automatic res_t advance_gesture(evt_t e);
        res_t r;
        case (e.func)
            FUNC_TICK:
                if (g_active) begin
                    tick_axis(0);
                    tick_axis(1);
                    if (g_speed[0] == '0 && g_speed[1] == '0)
                        end_gesture();
                    if (g_idle != IDLE_MAX)
                        g_idle = g_idle + 1'b1;
                    if (g_idle > c_idle)
                        end_gesture();
                end
            FUNC_PRESS:
            begin
                start_gesture(e.touch_x, e.touch_y);
                g_active = 1'b1;
                g_idle   = '0;
            end
            default:
            begin
                // move or release: while idle, both act as a press
                if (g_active) begin
                    move_axis(0, int'(g_base[0]) - int'(e.touch_x));
                    move_axis(1, int'(g_base[1]) - int'(e.touch_y));
                    if (e.func == FUNC_RELEASE)
                        g_active = 1'b0;
                end else begin
                    start_gesture(e.touch_x, e.touch_y);
                    g_active = 1'b1;
                end
                g_idle = '0;
            end
        endcase
        r.speed_x   = g_speed[0];
        r.speed_y   = g_speed[1];
        r.heading_x = g_head[0];
        r.heading_y = g_head[1];
        r.dragging  = g_active;
        return r;
    endfunction

    task automatic check_field(string name, logic [SPEED_W-1:0] want_v,
                               logic [SPEED_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            failed = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both channels and the register port at the rising edge.
    // Check an arriving readout before queuing the one for a new item, so a
    // spurious readout can never match the item taken at the same edge.
    // ------------------------------------------------------------------
    logic evt_took = 1'b0;

    always @(posedge clk) begin : watch
        res_t want;
        if (rst_n) begin
            evt_took <= evt_valid && !evt_stall;
            if (res_valid && !res_stall) begin
                if (readout_queue.size() == 0) begin
                    $error("readout item arrived with no expectation waiting");
                    failed = 1'b1;
                end else begin
                    want = readout_queue.pop_front();
                    check_field("speed_x", want.speed_x, res.speed_x);
                    check_field("speed_y", want.speed_y, res.speed_y);
                    check_field("heading_x", want.heading_x, res.heading_x);
                    check_field("heading_y", want.heading_y, res.heading_y);
                    check_field("dragging", want.dragging, res.dragging);
                end
            end
            if (evt_valid && !evt_stall)
                readout_queue.push_back(advance_gesture(evt));
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MOVE_THRESHOLD: c_thr    = cfg_data[THR_W-1:0];
                    CFG_TICK_PERIOD_MS: c_period = cfg_data[PERIOD_W-1:0];
                    CFG_IDLE_LIMIT:     c_idle   = cfg_data[IDLE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver and receiver pacing. Both change inputs at the falling edge.
    // Gaps are mostly short with an occasional long one; a calm flag, toggled
    // now and then, gives stretches with no idling at all.
    // ------------------------------------------------------------------
    int evt_gap    = 0;
    bit evt_calm   = 1'b0;
    int stall_left = 0;
    bit res_calm   = 1'b0;

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Hold the payload while stalled; advance only after an accepted item
    always @(negedge clk) begin
        if (rst_n && (!evt_valid || evt_took)) begin
            if (evt_gap > 0) begin
                evt_gap   <= evt_gap - 1;
                evt_valid <= 1'b0;
            end else if (touch_queue.size() > 0) begin
                evt       <= touch_queue.pop_front();
                evt_valid <= 1'b1;
                evt_gap   <= pick_gap(evt_calm);
                if ($urandom_range(0, 199) == 0)
                    evt_calm <= !evt_calm;
            end else begin
                evt_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin : stall_gen
        int len;
        len = 0;
        if (stall_left == 0 && $urandom_range(0, 2) == 0)
            len = pick_gap(res_calm);
        if (stall_left > 0) begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (len > 0) begin
            res_stall  <= 1'b1;
            stall_left <= len - 1;
        end else begin
            res_stall <= 1'b0;
        end
        if ($urandom_range(0, 299) == 0)
            res_calm <= !res_calm;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_evt(logic [1:0] f, int x, int y);
        evt_t e;
        e.func    = f;
        e.touch_x = TOUCH_W'(x);
        e.touch_y = TOUCH_W'(y);
        touch_queue.push_back(e);
    endtask

    function automatic int pick_coord();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 0;
        if (r == 1)
            return COORD_TOP;
        return $urandom_range(0, COORD_TOP);
    endfunction

    // Next offset (base minus touch) for one axis, kept so the touch stays on screen
    function automatic int next_offset(int off, int base);
        int r;
        int j;
        int step;
        r = $urandom_range(0, 9);
        if (r == 9)
            return $urandom_range(0, 1) ? base : base - COORD_TOP;
        if (r >= 7)
            return base - int'($urandom_range(0, COORD_TOP));
        if (r < 3) begin
            step = $urandom_range(0, 3);
        end else begin
            // land just below, on, or just above the threshold
            j = $urandom_range(0, 2);
            step = gen_thr + j - 1;
        end
        if ($urandom_range(0, 1))
            step = -step;
        off = off + step;
        if (off > base)
            off = base;
        if (off < base - COORD_TOP)
            off = base - COORD_TOP;
        return off;
    endfunction

    // One well-formed gesture: a start, moves mixed with ticks, usually a release
    task automatic add_gesture(int steps, int tick_pct);
        int bx, by, ox, oy, r;
        bx = pick_coord();
        by = pick_coord();
        ox = 0;
        oy = 0;
        r  = $urandom_range(0, 9);
        push_evt((r < 8) ? FUNC_PRESS : ((r == 8) ? FUNC_MOVE : FUNC_RELEASE), bx, by);
        repeat (steps) begin
            if ($urandom_range(0, 99) < tick_pct) begin
                push_evt(FUNC_TICK, $urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP));
            end else begin
                ox = next_offset(ox, bx);
                oy = next_offset(oy, by);
                push_evt(FUNC_MOVE, bx - ox, by - oy);
            end
        end
        if ($urandom_range(0, 9) < 6) begin
            ox = next_offset(ox, bx);
            oy = next_offset(oy, by);
            push_evt(FUNC_RELEASE, bx - ox, by - oy);
        end
    endtask

    // Mostly gestures with random content, some raw noise in between
    task automatic fill_random(int n);
        int goal;
        goal = touch_queue.size() + n;
        while (touch_queue.size() < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4))
                    push_evt(2'($urandom_range(0, 3)), $urandom_range(0, COORD_TOP),
                             $urandom_range(0, COORD_TOP));
            end else begin
                add_gesture($urandom_range(2, 20), $urandom_range(10, 45));
            end
        end
    endtask

    // One long gesture swinging between the screen edges: drives travel and
    // elapsed time into saturation when the threshold is too high to set a direction
    task automatic add_sweep(int n);
        bit far;
        far = 1'b1;
        push_evt(FUNC_PRESS, COORD_TOP, 0);
        repeat (n) begin
            if (far || $urandom_range(0, 1)) begin
                if (far)
                    push_evt(FUNC_MOVE, $urandom_range(0, 7), COORD_TOP - $urandom_range(0, 7));
                else
                    push_evt(FUNC_MOVE, COORD_TOP - $urandom_range(0, 7), $urandom_range(0, 7));
                far = !far;
            end else begin
                push_evt(FUNC_TICK, $urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP));
            end
        end
    endtask

    // Wait until every item is taken and every readout is back, then let the block settle
    task automatic drain();
        while (touch_queue.size() != 0 || evt_valid || readout_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_regs(int thr, int period, int idle);
        write_reg(CFG_MOVE_THRESHOLD, CFG_W'(thr));
        write_reg(CFG_TICK_PERIOD_MS, CFG_W'(period));
        write_reg(CFG_IDLE_LIMIT, CFG_W'(idle));
        gen_thr = thr;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: threshold 8, 10 ms per tick
        push_evt(FUNC_TICK, COORD_TOP, COORD_TOP);     // tick while idle: no change
        push_evt(FUNC_MOVE, COORD_TOP, COORD_TOP);     // move while idle starts a gesture
        push_evt(FUNC_MOVE, 0, 0);                     // largest positive offset
        push_evt(FUNC_TICK, 0, 0);
        push_evt(FUNC_MOVE, COORD_TOP, COORD_TOP);     // reversal to negative
        push_evt(FUNC_MOVE, COORD_TOP - 8, COORD_TOP - 8);  // change equal to threshold
        push_evt(FUNC_MOVE, COORD_TOP - 17, COORD_TOP - 17); // one past it: reversal
        push_evt(FUNC_TICK, 0, 0);
        push_evt(FUNC_RELEASE, COORD_TOP, 0);          // release while dragging
        push_evt(FUNC_TICK, 0, 0);
        push_evt(FUNC_RELEASE, 100, 3000);             // release while idle acts as press
        push_evt(FUNC_MOVE, 109, 2991);                // x takes negative direction from none, y positive
        push_evt(FUNC_PRESS, 2048, 2048);
        push_evt(FUNC_MOVE, 2056, 2040);               // offsets exactly at threshold
        push_evt(FUNC_TICK, 0, 0);
        push_evt(FUNC_PRESS, 500, 500);
        push_evt(FUNC_MOVE, 500, 400);                 // only one axis travels
        push_evt(FUNC_TICK, 0, 0);                     // still axis resets alone
        push_evt(FUNC_PRESS, 0, 0);
        push_evt(FUNC_TICK, 0, 0);                     // both speeds zero: gesture ends
        push_evt(FUNC_PRESS, 1, 1);
        push_evt(FUNC_MOVE, 1, 1);
        push_evt(FUNC_TICK, 0, 0);
        fill_random(250);
        drain();

        // Zero threshold, 1 ms period, timeout on the first tick
        set_regs(0, 1, 0);
        fill_random(150);
        drain();

        // Highest threshold, longest period, no timeout: saturate travel and time
        set_regs(COORD_TOP, 255, 65535);
        add_sweep(620);
        drain();

        // Zero period: elapsed time stays at zero, speed from travel alone
        set_regs(20, 0, 3);
        fill_random(150);
        drain();

        set_regs($urandom_range(1, 64), $urandom_range(1, 255), $urandom_range(2, 20));
        fill_random(150);
        drain();

        if (failed)
            $display("== FAIL ==");
        else
            $display("== PASS ==");
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
